FILE: design/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies; every other design file refers to it by scoped names.
package i2cm_pkg;

   // Width of the phase length register and tick counter
   localparam int unsigned PHASE_W     = 10;
   // Bits in one data byte, and the bit count that marks the ACK clock
   localparam int unsigned BYTE_W      = 8;
   localparam logic [3:0]  ACK_BIT_NUM = 4'd8;
   // Stream data widths, padded to whole bytes
   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned RSP_TDATA_W = 16;
   localparam int unsigned CMD_W       = 3;

   // Command codes as they arrive on the request tuser field
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 3'd0,
      CMD_START = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_READ  = 3'd3,
      CMD_STOP  = 3'd4
   } cmd_type;

   // Bus phases of the bit engine
   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_S1   = 4'd1,
      PH_S2   = 4'd2,
      PH_S3   = 4'd3,
      PH_S4   = 4'd4,
      PH_WLO  = 4'd5,
      PH_WHI  = 4'd6,
      PH_RLO  = 4'd7,
      PH_RHI  = 4'd8,
      PH_P1   = 4'd9,
      PH_P2   = 4'd10,
      PH_P3   = 4'd11,
      PH_P4   = 4'd12
   } phase_type;

   // One classified tick word, as it travels from the front to the engine
   typedef struct packed {
      cmd_type            kind;
      logic [BYTE_W-1:0]  tx_byte;
      logic               last_read;
      logic               scl_in;
      logic               sda_in;
   } item_type;

endpackage

FILE: design/i2cm_front.sv
// Request front end: unpacks the request stream and classifies the command.
// Depends on i2cm_pkg; feeds i2cm_queue.
module i2cm_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [i2cm_pkg::REQ_TDATA_W-1:0]   req_tdata,   // tx_byte[7:0], scl_in[8], sda_in[9]
   input  logic [i2cm_pkg::CMD_W-1:0]         req_tuser,   // cmd[2:0]
   input  logic                               req_tlast,   // last_read
   output logic                               push_valid,
   input  logic                               push_ready,
   output i2cm_pkg::item_type                 push_item
);

   i2cm_pkg::cmd_type kind;

   // Map the raw command code; undefined codes act as a plain tick
   always_comb begin
      unique case (req_tuser)
         i2cm_pkg::CMD_START: kind = i2cm_pkg::CMD_START;
         i2cm_pkg::CMD_WRITE: kind = i2cm_pkg::CMD_WRITE;
         i2cm_pkg::CMD_READ:  kind = i2cm_pkg::CMD_READ;
         i2cm_pkg::CMD_STOP:  kind = i2cm_pkg::CMD_STOP;
         default:             kind = i2cm_pkg::CMD_TICK;
      endcase
   end

   // Build the queue word
   always_comb begin
      push_item.kind      = kind;
      push_item.tx_byte   = req_tdata[i2cm_pkg::BYTE_W-1:0];
      push_item.last_read = req_tlast;
      push_item.scl_in    = req_tdata[i2cm_pkg::BYTE_W];
      push_item.sda_in    = req_tdata[i2cm_pkg::BYTE_W+1];
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

FILE: design/i2cm_queue.sv
// Short FIFO of classified tick words between the front end and the engine.
// Depends on i2cm_pkg for the word type.
module i2cm_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  i2cm_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output i2cm_pkg::item_type pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   i2cm_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/i2cm_engine.sv
// Back end: the I2C bit engine. Runs one tick per queued word and registers
// one result word per tick. Depends on i2cm_pkg.
module i2cm_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [i2cm_pkg::PHASE_W-1:0]       csr_data,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  i2cm_pkg::item_type                 pop_item,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [i2cm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int unsigned PW = i2cm_pkg::PHASE_W;
   localparam int unsigned BW = i2cm_pkg::BYTE_W;

   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0] phase_ticks_ff, phase_ticks_in;
   logic [PW-1:0] tick_ff, tick_in, tick_inc, tick_limit;
   logic [3:0]    bit_ff, bit_in;
   logic [BW-1:0] shift_ff, shift_in;
   logic [BW-1:0] rx_hold_ff, rx_hold_in;
   logic          ack_ff, ack_in;
   logic          scl_drv_ff, scl_drv_in;
   logic          sda_drv_ff, sda_drv_in;
   logic          rd_nack_ff, rd_nack_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [i2cm_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic          step, hold, advance, enter_en, finish, done;
   logic          byte_end;

   // Take a word whenever the result register is free or being drained
   assign pop_ready  = !rsp_valid_ff || rsp_tready;
   assign step       = pop_valid && pop_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Phase length; zero acts as one
   assign tick_limit = (phase_ticks_ff == '0) ? PW'(1) : phase_ticks_ff;
   assign tick_inc   = tick_ff + PW'(1);
   assign hold       = ((phase_ff == i2cm_pkg::PH_WHI) || (phase_ff == i2cm_pkg::PH_RHI))
                       && !pop_item.scl_in;
   assign advance    = step && (phase_ff != i2cm_pkg::PH_IDLE) && !hold
                       && (tick_inc >= tick_limit);
   assign byte_end   = (bit_ff >= i2cm_pkg::ACK_BIT_NUM);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step && phase_ff == i2cm_pkg::PH_IDLE) begin
         unique case (pop_item.kind)
            i2cm_pkg::CMD_START: phase_in = i2cm_pkg::PH_S1;
            i2cm_pkg::CMD_WRITE: phase_in = i2cm_pkg::PH_WLO;
            i2cm_pkg::CMD_READ:  phase_in = i2cm_pkg::PH_RLO;
            i2cm_pkg::CMD_STOP:  phase_in = i2cm_pkg::PH_P1;
            default:             phase_in = i2cm_pkg::PH_IDLE;
         endcase
      end else if (advance) begin
         unique case (phase_ff)
            i2cm_pkg::PH_S1:  phase_in = i2cm_pkg::PH_S2;
            i2cm_pkg::PH_S2:  phase_in = i2cm_pkg::PH_S3;
            i2cm_pkg::PH_S3:  phase_in = i2cm_pkg::PH_S4;
            i2cm_pkg::PH_WLO: phase_in = i2cm_pkg::PH_WHI;
            i2cm_pkg::PH_RLO: phase_in = i2cm_pkg::PH_RHI;
            i2cm_pkg::PH_WHI: phase_in = byte_end ? i2cm_pkg::PH_IDLE : i2cm_pkg::PH_WLO;
            i2cm_pkg::PH_RHI: phase_in = byte_end ? i2cm_pkg::PH_IDLE : i2cm_pkg::PH_RLO;
            i2cm_pkg::PH_P1:  phase_in = i2cm_pkg::PH_P2;
            i2cm_pkg::PH_P2:  phase_in = i2cm_pkg::PH_P3;
            i2cm_pkg::PH_P3:  phase_in = i2cm_pkg::PH_P4;
            default:          phase_in = i2cm_pkg::PH_IDLE;
         endcase
      end
   end

   assign enter_en = step && (phase_in != i2cm_pkg::PH_IDLE) && (phase_in != phase_ff);
   assign finish   = advance && (phase_in == i2cm_pkg::PH_IDLE);
   assign done     = finish;

   // Data path and line drives
   always_comb begin
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      rx_hold_in = rx_hold_ff;
      ack_in     = ack_ff;
      scl_drv_in = scl_drv_ff;
      sda_drv_in = sda_drv_ff;
      rd_nack_in = rd_nack_ff;
      if (step) begin
         if (phase_ff == i2cm_pkg::PH_IDLE) begin
            // Load a byte command
            case (pop_item.kind)
               i2cm_pkg::CMD_WRITE: begin
                  shift_in = pop_item.tx_byte;
                  bit_in   = '0;
                  ack_in   = 1'b0;
               end
               i2cm_pkg::CMD_READ: begin
                  shift_in   = '0;
                  bit_in     = '0;
                  ack_in     = 1'b0;
                  rd_nack_in = pop_item.last_read;
               end
               default: ;
            endcase
         end else if (!hold) begin
            tick_in = tick_inc;
            if (advance) begin
               // Close a data high phase: next bit or byte end
               case (phase_ff)
                  i2cm_pkg::PH_WHI: begin
                     if (byte_end) begin
                        ack_in     = pop_item.sda_in;
                        scl_drv_in = 1'b1;
                     end else begin
                        shift_in = {shift_ff[BW-2:0], 1'b0};
                        bit_in   = bit_ff + 4'd1;
                     end
                  end
                  i2cm_pkg::PH_RHI: begin
                     if (byte_end) begin
                        rx_hold_in = shift_ff;
                        scl_drv_in = 1'b1;
                     end else begin
                        shift_in = {shift_ff[BW-2:0], pop_item.sda_in};
                        bit_in   = bit_ff + 4'd1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         if (finish) begin
            tick_in = '0;
         end
         // Set the lines for the phase being entered
         if (enter_en) begin
            tick_in = '0;
            case (phase_in)
               i2cm_pkg::PH_S1:  sda_drv_in = 1'b0;
               i2cm_pkg::PH_S2:  scl_drv_in = 1'b0;
               i2cm_pkg::PH_S3:  sda_drv_in = 1'b1;
               i2cm_pkg::PH_S4:  scl_drv_in = 1'b1;
               i2cm_pkg::PH_WLO: begin
                  scl_drv_in = 1'b1;
                  sda_drv_in = (bit_in < i2cm_pkg::ACK_BIT_NUM) ? !shift_in[BW-1] : 1'b0;
               end
               i2cm_pkg::PH_RLO: begin
                  scl_drv_in = 1'b1;
                  sda_drv_in = (bit_in < i2cm_pkg::ACK_BIT_NUM) ? 1'b0 : !rd_nack_in;
               end
               i2cm_pkg::PH_WHI: scl_drv_in = 1'b0;
               i2cm_pkg::PH_RHI: scl_drv_in = 1'b0;
               i2cm_pkg::PH_P1:  scl_drv_in = 1'b1;
               i2cm_pkg::PH_P2:  sda_drv_in = 1'b1;
               i2cm_pkg::PH_P3:  scl_drv_in = 1'b0;
               i2cm_pkg::PH_P4:  sda_drv_in = 1'b0;
               default: ;
            endcase
         end
      end
   end

   // Phase length register
   assign phase_ticks_in = csr_valid ? csr_data : phase_ticks_ff;

   // Result register: rx_byte[12:5], nack[4], done[3], busy[2], sda[1], scl[0]
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, rx_hold_in, ack_in, done,
                         (phase_in != i2cm_pkg::PH_IDLE), sda_drv_in, scl_drv_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= i2cm_pkg::PH_IDLE;
         phase_ticks_ff <= PW'(1);
         tick_ff        <= '0;
         bit_ff         <= '0;
         shift_ff       <= '0;
         rx_hold_ff     <= '0;
         ack_ff         <= 1'b0;
         scl_drv_ff     <= 1'b0;
         sda_drv_ff     <= 1'b0;
         rd_nack_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         phase_ticks_ff <= phase_ticks_in;
         tick_ff        <= tick_in;
         bit_ff         <= bit_in;
         shift_ff       <= shift_in;
         rx_hold_ff     <= rx_hold_in;
         ack_ff         <= ack_in;
         scl_drv_ff     <= scl_drv_in;
         sda_drv_ff     <= sda_drv_in;
         rd_nack_ff     <= rd_nack_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: design/i2c_master_byte_engine_unit.sv
// I2C master byte engine top level: front end, tick queue and bit engine.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_engine.
//
// Usage:
//   Each request word is one tick of the bit engine. It carries a command
//   (tick only, start, write byte, read byte, stop) on req_tuser, the byte to
//   send and the sampled SCL/SDA levels on req_tdata, and the last-read flag
//   on req_tlast. Commands are taken only while the engine is idle; otherwise
//   the word is just a tick. Every request word yields exactly one response
//   word with the line drives, busy, done, NACK status and received byte.
//   The csr channel writes the phase length in ticks (zero acts as one); it is
//   always ready and is to be written only while the block is idle.
// Timing:
//   One word per clock sustained while the receiver does not stall. A response
//   passes through the tick queue and then through the engine's state update
//   into the result register.
// Reset and stall:
//   Reset idles the engine, releases both lines, sets the phase length to one
//   and empties the queue. When the receiver stalls, the result register
//   holds, the engine stops, and the queue absorbs up to QUEUE_DEPTH words
//   before req_tready drops.
module i2c_master_byte_engine_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [i2cm_pkg::REQ_TDATA_W-1:0]   req_tdata,  // tx_byte[7:0], scl_in[8], sda_in[9]
   input  logic [i2cm_pkg::CMD_W-1:0]         req_tuser,  // cmd[2:0]
   input  logic                               req_tlast,  // last_read
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [i2cm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // scl_pull_low[0], sda_pull_low[1],
                                                          // busy_res[2], done_res[3],
                                                          // nack_seen[4], rx_byte[12:5]
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [i2cm_pkg::PHASE_W-1:0]       csr_data    // phase_ticks
);

   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;
   i2cm_pkg::item_type push_item, pop_item;

   assign csr_ready = 1'b1;

   i2cm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   i2cm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   i2cm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: verif/tb_i2c_master_byte_engine_unit.sv
// Self-checking testbench for the I2C master byte engine top level.
// Needs i2cm_pkg and the design files; it predicts every response word from its own bus model.
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine_unit;

   localparam int          CYCLE_LIMIT      = 2_000_000;
   localparam int          RANDOM_WORDS     = 700;
   localparam int          MAX_REPORTS      = 10;
   localparam logic [2:0]  CMD_FIRST_UNUSED = 3'd5;
   localparam logic [2:0]  CMD_LAST_CODE    = 3'd7;
   // How the SDA level is chosen for the ticks of one command
   localparam int          SDA_LOW          = 0;
   localparam int          SDA_RELEASE      = 1;
   localparam int          SDA_RANDOM       = 2;

   // One request word: a tick with an optional command
   typedef struct {
      logic [2:0] cmd;
      logic [7:0] tx_byte;
      logic       last_read;
      logic       scl_in;
      logic       sda_in;
   } tick_word_type;

   // One response word: line drives and status
   typedef struct {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy;
      logic       done;
      logic       nack_seen;
      logic [7:0] rx_byte;
   } line_state_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [i2cm_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [i2cm_pkg::CMD_W-1:0]       req_tuser = '0;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [i2cm_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [i2cm_pkg::PHASE_W-1:0]     csr_data = '0;

   // Bus model state
   i2cm_pkg::phase_type          eng_phase;
   logic [3:0]                   bit_cnt;
   logic [7:0]                   shift_byte;
   logic [i2cm_pkg::PHASE_W-1:0] tick_cnt;
   logic [i2cm_pkg::PHASE_W-1:0] phase_len;
   logic                         ack_bit;
   logic                         scl_drv;
   logic                         sda_drv;
   logic [7:0]                   rx_hold;
   logic                         rd_nack;
   logic                         done_bit;

   tick_word_type  pending_ticks[$];
   line_state_type tick_response_q[$];

   int    cycle_cnt = 0;
   int    mismatch_cnt = 0;
   int    words_checked = 0;
   int    words_queued = 0;
   int    held_ticks = 0;
   int    cfg_writes = 0;
   int    cmd_count[8];
   bit    req_taken = 1'b0;
   int    burst_left = 1;
   int    gap_left = 0;
   int    stall_step = 0;
   logic [15:0] stall_bits = '1;

   i2c_master_byte_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Bus model
   // ---------------------------------------------------------------
   function automatic void reset_bus_model();
      eng_phase  = i2cm_pkg::PH_IDLE;
      bit_cnt    = '0;
      shift_byte = '0;
      tick_cnt   = '0;
      phase_len  = 10'd1;
      ack_bit    = 1'b0;
      scl_drv    = 1'b0;
      sda_drv    = 1'b0;
      rx_hold    = '0;
      rd_nack    = 1'b0;
      done_bit   = 1'b0;
   endfunction

   // Open a phase and set the line it changes
   function automatic void enter_phase(i2cm_pkg::phase_type s);
      eng_phase = s;
      tick_cnt  = '0;
      case (s) inside
         i2cm_pkg::PH_S1: sda_drv = 1'b0;
         i2cm_pkg::PH_S2: scl_drv = 1'b0;
         i2cm_pkg::PH_S3: sda_drv = 1'b1;
         i2cm_pkg::PH_S4: scl_drv = 1'b1;
         i2cm_pkg::PH_WLO: begin
            scl_drv = 1'b1;
            sda_drv = (bit_cnt < i2cm_pkg::ACK_BIT_NUM) ? ~shift_byte[7] : 1'b0;
         end
         i2cm_pkg::PH_RLO: begin
            scl_drv = 1'b1;
            sda_drv = (bit_cnt < i2cm_pkg::ACK_BIT_NUM) ? 1'b0 : ~rd_nack;
         end
         i2cm_pkg::PH_WHI, i2cm_pkg::PH_RHI: scl_drv = 1'b0;
         i2cm_pkg::PH_P1: scl_drv = 1'b1;
         i2cm_pkg::PH_P2: sda_drv = 1'b1;
         i2cm_pkg::PH_P3: scl_drv = 1'b0;
         i2cm_pkg::PH_P4: sda_drv = 1'b0;
         default: ;
      endcase
   endfunction

   function automatic void end_command();
      eng_phase = i2cm_pkg::PH_IDLE;
      tick_cnt  = '0;
      done_bit  = 1'b1;
   endfunction

   // Advance to the next phase once the current one has run out
   function automatic void close_phase(logic sda);
      case (eng_phase)
         i2cm_pkg::PH_S1:  enter_phase(i2cm_pkg::PH_S2);
         i2cm_pkg::PH_S2:  enter_phase(i2cm_pkg::PH_S3);
         i2cm_pkg::PH_S3:  enter_phase(i2cm_pkg::PH_S4);
         i2cm_pkg::PH_WLO: enter_phase(i2cm_pkg::PH_WHI);
         i2cm_pkg::PH_RLO: enter_phase(i2cm_pkg::PH_RHI);
         i2cm_pkg::PH_WHI: begin
            if (bit_cnt >= i2cm_pkg::ACK_BIT_NUM) begin
               ack_bit = sda;
               scl_drv = 1'b1;
               end_command();
            end else begin
               shift_byte = shift_byte << 1;
               bit_cnt++;
               enter_phase(i2cm_pkg::PH_WLO);
            end
         end
         i2cm_pkg::PH_RHI: begin
            if (bit_cnt >= i2cm_pkg::ACK_BIT_NUM) begin
               rx_hold = shift_byte;
               scl_drv = 1'b1;
               end_command();
            end else begin
               shift_byte = {shift_byte[6:0], sda};
               bit_cnt++;
               enter_phase(i2cm_pkg::PH_RLO);
            end
         end
         i2cm_pkg::PH_P1: enter_phase(i2cm_pkg::PH_P2);
         i2cm_pkg::PH_P2: enter_phase(i2cm_pkg::PH_P3);
         i2cm_pkg::PH_P3: enter_phase(i2cm_pkg::PH_P4);
         default: end_command();
      endcase
   endfunction

   // Run one tick and return the line state it leaves
   function automatic line_state_type compute_tick_response(tick_word_type w);
      line_state_type               r;
      logic [i2cm_pkg::PHASE_W-1:0] len_eff;
      len_eff  = (phase_len == '0) ? 10'd1 : phase_len;
      done_bit = 1'b0;
      if (eng_phase == i2cm_pkg::PH_IDLE) begin
         case (w.cmd)
            i2cm_pkg::CMD_START: begin
               cmd_count[w.cmd]++;
               enter_phase(i2cm_pkg::PH_S1);
            end
            i2cm_pkg::CMD_WRITE: begin
               cmd_count[w.cmd]++;
               shift_byte = w.tx_byte;
               bit_cnt    = '0;
               ack_bit    = 1'b0;
               enter_phase(i2cm_pkg::PH_WLO);
            end
            i2cm_pkg::CMD_READ: begin
               cmd_count[w.cmd]++;
               shift_byte = '0;
               bit_cnt    = '0;
               ack_bit    = 1'b0;
               rd_nack    = w.last_read;
               enter_phase(i2cm_pkg::PH_RLO);
            end
            i2cm_pkg::CMD_STOP: begin
               cmd_count[w.cmd]++;
               enter_phase(i2cm_pkg::PH_P1);
            end
            default: ;
         endcase
      end else if ((eng_phase == i2cm_pkg::PH_WHI || eng_phase == i2cm_pkg::PH_RHI)
                   && !w.scl_in) begin
         // slave stretches the clock: hold the count
         held_ticks++;
      end else begin
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt >= len_eff)
            close_phase(w.sda_in);
      end
      r.scl_pull_low = scl_drv;
      r.sda_pull_low = sda_drv;
      r.busy         = (eng_phase != i2cm_pkg::PH_IDLE);
      r.done         = done_bit;
      r.nack_seen    = ack_bit;
      r.rx_byte      = rx_hold;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Request driver: bursts with random gaps, changes on the falling edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : accept_request
      tick_word_type w;
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         w = pending_ticks.pop_front();
         tick_response_q.push_back(compute_tick_response(w));
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the word until it is taken
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
         req_tvalid <= 1'b1;
         req_tuser  <= pending_ticks[0].cmd;
         req_tlast  <= pending_ticks[0].last_read;
         req_tdata  <= {6'b0, pending_ticks[0].sda_in, pending_ticks[0].scl_in,
                        pending_ticks[0].tx_byte};
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver stalls on a rotating pattern; each reload is all ready or random
   always @(negedge clock) begin
      if (stall_step % 48 == 0)
         stall_bits = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      stall_step++;
      rsp_tready <= stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[15:1]};
   end

   // ---------------------------------------------------------------
   // Response monitor and scoreboard
   // ---------------------------------------------------------------
   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         if (mismatch_cnt < MAX_REPORTS)
            $display("word %0d: %s expected %0h, got %0h",
                     words_checked, name, exp_val, act_val);
         mismatch_cnt++;
      end
   endtask

   always @(posedge clock) begin : check_response
      line_state_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tick_response_q.size() == 0) begin
            if (mismatch_cnt < MAX_REPORTS)
               $display("word %0d: response %0h with nothing expected",
                        words_checked, rsp_tdata);
            mismatch_cnt++;
         end else begin
            e = tick_response_q.pop_front();
            check_field("scl_pull_low", int'(e.scl_pull_low), int'(rsp_tdata[0]));
            check_field("sda_pull_low", int'(e.sda_pull_low), int'(rsp_tdata[1]));
            check_field("busy", int'(e.busy), int'(rsp_tdata[2]));
            check_field("done", int'(e.done), int'(rsp_tdata[3]));
            check_field("nack_seen", int'(e.nack_seen), int'(rsp_tdata[4]));
            check_field("rx_byte", int'(e.rx_byte), int'(rsp_tdata[12:5]));
         end
         words_checked++;
      end
   end

   // Cycle watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic logic pick_scl(int stretch_pct);
      return ($urandom_range(0, 99) >= stretch_pct);
   endfunction

   function automatic logic pick_sda(int sda_sel);
      if (sda_sel == SDA_LOW)
         return 1'b0;
      if (sda_sel == SDA_RELEASE)
         return 1'b1;
      return 1'($urandom);
   endfunction

   task automatic push_tick(logic [2:0] cmd, logic [7:0] txb, logic last,
                            logic scl, logic sda);
      tick_word_type w;
      w.cmd       = cmd;
      w.tx_byte   = txb;
      w.last_read = last;
      w.scl_in    = scl;
      w.sda_in    = sda;
      pending_ticks.push_back(w);
      words_queued++;
   endtask

   // Wait until the driver has handed over every queued word
   task automatic wait_drain();
      do begin
         @(posedge clock);
         #0.1;
      end while (pending_ticks.size() != 0);
   endtask

   // Feed ticks until the model reports the engine idle
   task automatic complete_cmd(int stretch_pct, int sda_sel);
      int n;
      wait_drain();
      while (eng_phase != i2cm_pkg::PH_IDLE) begin
         n = $urandom_range(1, 24);
         repeat (n)
            push_tick(($urandom_range(0, 9) == 0) ? 3'($urandom) : i2cm_pkg::CMD_TICK,
                      8'($urandom), 1'($urandom), pick_scl(stretch_pct), pick_sda(sda_sel));
         wait_drain();
      end
   endtask

   task automatic run_cmd(logic [2:0] cmd, logic [7:0] txb, logic last,
                          int stretch_pct, int sda_sel);
      push_tick(cmd, txb, last, pick_scl(stretch_pct), pick_sda(sda_sel));
      complete_cmd(stretch_pct, sda_sel);
   endtask

   // Drain everything and let the block go quiet before a register write
   task automatic settle();
      complete_cmd(0, SDA_RANDOM);
      do begin
         @(posedge clock);
         #0.1;
      end while (tick_response_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_phase_len(logic [i2cm_pkg::PHASE_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      phase_len = v;
      cfg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One bus transfer: address, a few data bytes, usually a stop
   task automatic run_transfer();
      int         stretch;
      int         nbytes;
      logic [7:0] addr;
      stretch = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      addr    = 8'($urandom);
      nbytes  = $urandom_range(1, 3);
      run_cmd(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom), stretch, SDA_RANDOM);
      run_cmd(i2cm_pkg::CMD_WRITE, addr, 1'($urandom), stretch, SDA_RANDOM);
      for (int i = 0; i < nbytes; i++) begin
         if (addr[0])
            run_cmd(i2cm_pkg::CMD_READ, 8'($urandom),
                    (i == nbytes - 1) ^ ($urandom_range(0, 7) == 0), stretch, SDA_RANDOM);
         else
            run_cmd(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), stretch, SDA_RANDOM);
      end
      if ($urandom_range(0, 9) != 0)
         run_cmd(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), stretch, SDA_RANDOM);
   endtask

   initial begin : stimulus
      int random_end;
      int next_cfg_at;
      foreach (cmd_count[i]) cmd_count[i] = 0;
      reset_bus_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Idle ticks and undefined codes do nothing
      run_cmd(i2cm_pkg::CMD_TICK, 8'hFF, 1'b1, 0, SDA_RANDOM);
      for (logic [3:0] c = 4'(CMD_FIRST_UNUSED); c <= 4'(CMD_LAST_CODE); c++)
         run_cmd(c[2:0], 8'($urandom), 1'($urandom), 0, SDA_RANDOM);

      // Writes with ACK and NACK, reads with ACK and NACK, repeated start
      run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
      run_cmd(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, 0, SDA_LOW);
      run_cmd(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, 0, SDA_RELEASE);
      run_cmd(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0, 50, SDA_RANDOM);
      run_cmd(i2cm_pkg::CMD_READ, 8'h00, 1'b0, 0, SDA_RELEASE);
      run_cmd(i2cm_pkg::CMD_READ, 8'hFF, 1'b1, 0, SDA_LOW);
      run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
      run_cmd(i2cm_pkg::CMD_WRITE, 8'h5A, 1'b0, 0, SDA_RANDOM);
      run_cmd(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 30, SDA_RANDOM);
      run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);

      // A command issued while busy is only a tick
      push_tick(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 1'b1);
      push_tick(i2cm_pkg::CMD_WRITE, 8'hC3, 1'b0, 1'b1, 1'b1);
      push_tick(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b1);
      complete_cmd(0, SDA_RANDOM);

      // Zero phase length acts as one
      settle();
      write_phase_len(10'd0);
      run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
      run_cmd(i2cm_pkg::CMD_WRITE, 8'h96, 1'b0, 20, SDA_RANDOM);
      run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);

      // Long phase length, start and stop only
      settle();
      write_phase_len(10'd32);
      run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, SDA_RANDOM);
      run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);

      // Random part: mostly well-formed transfers, some stray commands
      settle();
      write_phase_len(10'd2);
      random_end  = words_queued + RANDOM_WORDS;
      next_cfg_at = words_queued + 250;
      while (words_queued < random_end) begin
         if (words_queued >= next_cfg_at) begin
            settle();
            case ($urandom_range(0, 4))
               0: write_phase_len(10'd0);
               1: write_phase_len(10'd1);
               2: write_phase_len(10'($urandom_range(5, 12)));
               default: write_phase_len(10'($urandom_range(1, 4)));
            endcase
            next_cfg_at = words_queued + 250;
         end
         if ($urandom_range(0, 9) < 7)
            run_transfer();
         else
            run_cmd(3'($urandom), 8'($urandom), 1'($urandom),
                    $urandom_range(0, 30), SDA_RANDOM);
      end

      settle();
      $display("Checked %0d response words over %0d phase length writes, %0d stretched ticks",
               words_checked, cfg_writes, held_ticks);
      $display("Commands run: %0d start, %0d write, %0d read, %0d stop",
               cmd_count[i2cm_pkg::CMD_START], cmd_count[i2cm_pkg::CMD_WRITE],
               cmd_count[i2cm_pkg::CMD_READ], cmd_count[i2cm_pkg::CMD_STOP]);
      if (mismatch_cnt == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatch_cnt);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_queue.sv
design/i2cm_engine.sv
design/i2c_master_byte_engine_unit.sv
verif/tb_i2c_master_byte_engine_unit.sv
